FILE: design/msp_pkg.sv
// Shared types, constants and helpers for the multi-stack shared pool.
`timescale 1ns / 1ps

package msp_pkg;

	localparam int CAPACITY = 64;
	localparam int STACKS   = 4;

	localparam int PTR_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int STK_W = $clog2(STACKS);
	localparam int SID_W = 2;
	localparam int VAL_W = 32;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam ptr_t NULL_PTR = ptr_t'(CAPACITY);

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                    kind;
		logic [SID_W-1:0]        stack_id;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [VAL_W-1:0] pop_data;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic commit;
	} msp_cmd_t;

	// Link value of a slot that has not been rewritten since reset.
	function automatic ptr_t link_init(idx_t idx);
		ptr_t nxt;
		nxt = ptr_t'(idx) + ptr_t'(1);
		if (idx == idx_t'(CAPACITY - 1)) begin
			nxt = NULL_PTR;
		end
		return nxt;
	endfunction

endpackage

FILE: design/msp_ctrl.sv
// Controller state machine: accepts items, sequences commit and result handoff.
`timescale 1ns / 1ps

module msp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output msp_pkg::msp_cmd_t cmd
);

	typedef enum logic {
		IDLE,
		EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   load;
	logic   commit;

	assign load      = (state_q == IDLE) && req_valid;
	// Commit only when the result register is free or being drained.
	assign commit    = (state_q == EXEC) && (!rsp_valid_q || !rsp_stall);
	assign req_stall = (state_q != IDLE);
	assign rsp_valid = rsp_valid_q;
	assign cmd.load   = load;
	assign cmd.commit = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (load) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					if (commit) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/msp_dpath.sv
// Datapath: pointers, link and element memories, result register.
`timescale 1ns / 1ps

module msp_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  msp_pkg::msp_cmd_t cmd,
	input  msp_pkg::req_t     req,
	output msp_pkg::rsp_t     rsp
);

	msp_pkg::ptr_t tops_q [msp_pkg::STACKS];
	msp_pkg::ptr_t free_head_q;
	logic [msp_pkg::CAPACITY-1:0] link_vld_q;

	msp_pkg::ptr_t link_mem [msp_pkg::CAPACITY];
	logic signed [msp_pkg::VAL_W-1:0] elem_mem [msp_pkg::CAPACITY];

	logic                             kind_q;
	logic [msp_pkg::STK_W-1:0]        sid_q;
	logic signed [msp_pkg::VAL_W-1:0] value_q;
	msp_pkg::ptr_t                    slot_q;
	msp_pkg::ptr_t                    top_q;
	msp_pkg::ptr_t                    link_rd_q;
	logic                             link_v_q;
	logic signed [msp_pkg::VAL_W-1:0] elem_rd_q;
	msp_pkg::rsp_t                    rsp_q;

	logic [msp_pkg::STK_W-1:0] req_sid;
	msp_pkg::ptr_t             req_top;
	msp_pkg::ptr_t             rd_ptr;
	msp_pkg::idx_t             rd_idx;
	msp_pkg::idx_t             slot_idx;
	logic                      slot_ok;
	msp_pkg::ptr_t             link_val;
	msp_pkg::rsp_t             rsp_d;
	logic                      push_go;
	logic                      pop_go;

	always_comb begin
		req_sid  = req.stack_id[msp_pkg::STK_W-1:0];
		req_top  = tops_q[req_sid];
		rd_ptr   = (req.kind == msp_pkg::KIND_PUSH) ? free_head_q : req_top;
		rd_idx   = rd_ptr[msp_pkg::IDX_W-1:0];
		slot_idx = slot_q[msp_pkg::IDX_W-1:0];
		slot_ok  = slot_q < msp_pkg::NULL_PTR;
		// A slot never relinked still holds its reset successor.
		link_val = link_v_q ? link_rd_q : msp_pkg::link_init(slot_idx);
		push_go  = cmd.commit && slot_ok && (kind_q == msp_pkg::KIND_PUSH);
		pop_go   = cmd.commit && slot_ok && (kind_q == msp_pkg::KIND_POP);
		rsp_d.pop_data = '0;
		if (!slot_ok) begin
			rsp_d.status = (kind_q == msp_pkg::KIND_PUSH) ? msp_pkg::ST_FULL
				: msp_pkg::ST_EMPTY;
		end else begin
			rsp_d.status = msp_pkg::ST_OK;
			if (kind_q == msp_pkg::KIND_POP) begin
				rsp_d.pop_data = elem_rd_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < msp_pkg::STACKS; i++) begin
				tops_q[i] <= msp_pkg::NULL_PTR;
			end
			free_head_q <= '0;
			link_vld_q  <= '0;
		end else begin
			if (push_go) begin
				free_head_q          <= link_val;
				tops_q[sid_q]        <= slot_q;
				link_vld_q[slot_idx] <= 1'b1;
			end else if (pop_go) begin
				tops_q[sid_q]        <= link_val;
				free_head_q          <= slot_q;
				link_vld_q[slot_idx] <= 1'b1;
			end
		end
	end

	// Capture the item and read both memories at the slot it addresses; load the result register on commit.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= req.kind;
			sid_q     <= req_sid;
			value_q   <= req.value;
			slot_q    <= rd_ptr;
			top_q     <= req_top;
			link_rd_q <= link_mem[rd_idx];
			link_v_q  <= link_vld_q[rd_idx];
			elem_rd_q <= elem_mem[rd_idx];
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push_go) begin
			link_mem[slot_idx] <= top_q;
			elem_mem[slot_idx] <= value_q;
		end else if (pop_go) begin
			link_mem[slot_idx] <= free_head_q;
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: design/multi_stack_shared_pool_unit.sv
// Top level of the multi-stack shared pool: controller plus datapath.
`timescale 1ns / 1ps

// Four LIFO stacks share a pool of 64 slots, linked through a free list.
// Request channel (req_valid, req_stall, req): each item is a push of
// req.value onto stack req.stack_id (kind 0) or a pop from it (kind 1).
// Response channel (rsp_valid, rsp_stall, rsp): exactly one item per
// request, carrying status (ok, pool full, stack empty) and the popped
// value, zero unless a pop succeeded.
// Timing: a request is taken in the cycle it is offered while the block
// is idle; the link and element memories are read at that edge and the
// update commits in the EXEC state once the response register is free or
// draining, which also loads it. The registered read of the link memory
// before its rewrite means no new request is taken until the last commits.
// A stalled response holds in its register; the block takes the next
// request meanwhile but does not commit it until the register drains.
// Reset empties every stack and rebuilds the free list at once via per-slot
// link valid bits; no clearing pass is needed.
module multi_stack_shared_pool_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  msp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output msp_pkg::rsp_t rsp
);

	msp_pkg::msp_cmd_t cmd;

	msp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	msp_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	a_no_load_and_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.commit))
		else $error("load and commit in the same cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while an item is in flight");

	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.commit))
		else $error("response raised without a commit");

	a_commit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && rsp_valid) |-> !rsp_stall)
		else $error("commit overwrote a stalled response");

endmodule

FILE: test/stack_pool_checker.sv
// Checker for the shared-pool stack unit: predicts each response and compares it.
`timescale 1ns / 1ps

module stack_pool_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  msp_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  msp_pkg::rsp_t rsp,
	output int            fail_count,
	output int            rsp_outstanding
);
	import msp_pkg::*;

	ptr_t                    next_slot  [CAPACITY];
	logic signed [VAL_W-1:0] slot_value [CAPACITY];
	ptr_t                    top_slot   [STACKS];
	ptr_t                    free_slot;

	rsp_t pending_rsps [$];

	task automatic clear_pool();
		for (int i = 0; i < CAPACITY; i++) begin
			next_slot[i]  = (i == CAPACITY - 1) ? NULL_PTR : ptr_t'(i + 1);
			slot_value[i] = '0;
		end
		for (int s = 0; s < STACKS; s++) begin
			top_slot[s] = NULL_PTR;
		end
		free_slot = '0;
	endtask

	// Apply one push or pop to the predicted pool and return its response.
	function automatic rsp_t apply_stack_op(req_t op);
		rsp_t r;
		int   sid;
		ptr_t slot;
		idx_t idx;
		r.status   = ST_OK;
		r.pop_data = '0;
		sid = int'(op.stack_id) % STACKS;
		if (op.kind == KIND_PUSH) begin
			slot = free_slot;
			idx  = slot[IDX_W-1:0];
			if (slot >= ptr_t'(CAPACITY)) begin
				r.status = ST_FULL;
			end else begin
				free_slot       = next_slot[idx];
				next_slot[idx]  = top_slot[sid];
				top_slot[sid]   = slot;
				slot_value[idx] = op.value;
			end
		end else begin
			slot = top_slot[sid];
			idx  = slot[IDX_W-1:0];
			if (slot >= ptr_t'(CAPACITY)) begin
				r.status = ST_EMPTY;
			end else begin
				top_slot[sid]  = next_slot[idx];
				next_slot[idx] = free_slot;
				free_slot      = slot;
				r.pop_data     = slot_value[idx];
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			clear_pool();
			pending_rsps.delete();
			fail_count      = 0;
			rsp_outstanding = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsps.size() == 0) begin
					if (fail_count < 10) begin
						$display("%0t: response with none expected: status %0d value %0d",
							$realtime, rsp.status, rsp.pop_data);
					end
					fail_count++;
				end else begin
					want = pending_rsps.pop_front();
					if (rsp.status !== want.status
						|| rsp.pop_data !== want.pop_data) begin
						if (fail_count < 10) begin
							$display({"%0t: mismatch: expected status %0d value %0d,",
								" got status %0d value %0d"},
								$realtime, want.status, want.pop_data,
								rsp.status, rsp.pop_data);
						end
						fail_count++;
					end
				end
			end
			// predict after the compare so a same-edge request never matches itself
			if (req_valid && !req_stall) begin
				pending_rsps.push_back(apply_stack_op(req));
			end
			rsp_outstanding = pending_rsps.size();
		end
	end

endmodule

FILE: test/tb_multi_stack_shared_pool_unit.sv
// Testbench top for the shared-pool stack unit: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_multi_stack_shared_pool_unit;
	import msp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int BLOCKS      = 6;
	localparam int BLOCK_OPS   = 75;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int fail_count;
	int rsp_outstanding;
	int idle_pct  = 0;
	int stall_pct = 0;
	int cycles    = 0;

	multi_stack_shared_pool_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	stack_pool_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp             (rsp),
		.fail_count      (fail_count),
		.rsp_outstanding (rsp_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_op(input logic kind, input int sid, input logic signed [VAL_W-1:0] val);
		req_t item;
		item.kind     = kind;
		item.stack_id = SID_W'(sid);
		item.value    = val;
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
	endtask

	// Hold off new items until every predicted response has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (rsp_outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int push_pct;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops on empty stacks, extreme values, LIFO order within one stack
		for (int s = 0; s < STACKS; s++) send_op(KIND_POP, s, 32'sh0);
		send_op(KIND_PUSH, 0, 32'sh7FFF_FFFF);
		send_op(KIND_PUSH, 1, 32'sh8000_0000);
		send_op(KIND_PUSH, 2, 32'sh0);
		send_op(KIND_PUSH, 3, -32'sd1);
		send_op(KIND_PUSH, 0, 32'sh5555_5555);
		send_op(KIND_PUSH, 0, 32'shAAAA_AAAA);
		for (int k = 0; k < 4; k++) send_op(KIND_POP, 0, -32'sd1);
		send_op(KIND_POP, 1, 32'sh1234_5678);
		send_op(KIND_POP, 2, 32'sh0);
		send_op(KIND_POP, 3, 32'sh7FFF_FFFF);
		send_op(KIND_POP, 3, 32'sh0);
		wait_drained();

		// alternate filling past capacity and draining past empty
		for (int b = 0; b < BLOCKS; b++) begin
			case (b % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 49; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 49; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			push_pct = (b % 2 == 0) ? 97 : 3;
			for (int n = 0; n < BLOCK_OPS; n++) begin
				send_op(($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP,
					$urandom_range(0, STACKS - 1), $urandom);
			end
			wait_drained();
		end

		stall_pct = 0;
		repeat (10) @(posedge clk);
		if (fail_count == 0 && rsp_outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
